@@ rtl/i2csra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C slave register access - package
// Event kinds, transmit byte selects and protocol constants.
// ----------------------------------------------------------------------------
package i2csra_pkg;

	localparam logic [7:0] CMD_READ  = 8'd1;
	localparam logic [7:0] CMD_WRITE = 8'd2;

	localparam logic [2:0] POS_CMD   = 3'd0;
	localparam logic [2:0] POS_INDEX = 3'd1;
	localparam logic [2:0] POS_LOW   = 3'd2;
	localparam logic [2:0] POS_HIGH  = 3'd3;
	localparam logic [2:0] POS_MAX   = 3'd4;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_NACK,
		KIND_RD_DATA,
		KIND_RD_ADDR,
		KIND_WR_DATA,
		KIND_WR_ADDR
	} kind_t;

	typedef enum logic [1:0] {
		TX_NONE,
		TX_LOW,
		TX_HIGH,
		TX_ZERO
	} tx_sel_t;

endpackage
`default_nettype wire

@@ rtl/i2c_slave_register_access.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C slave register access
// Decodes one slave bus event per item and serves a 16-bit register file.
// ----------------------------------------------------------------------------
// One item is accepted every clock cycle while out_stall stays low. Each item
// gives one result, registered first by the register-file read stage (the
// low and high byte lanes are separate synchronous memories with a registered
// read) and then by the output register. The result stage and the read stage
// each hold one item, so one more item is accepted while a result waits on
// out_stall; after that in_stall stays high until the result is taken. Reset
// clears the register file at once through per-entry valid bits; no clearing
// pass is needed.
module i2c_slave_register_access
	import i2csra_pkg::*;
#(
	parameter int NUM_REGS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       start_seen,
	input  wire logic       is_data,
	input  wire logic       is_read,
	input  wire logic       buffer_full,
	input  wire logic       clock_released,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            tx_valid,
	output logic [7:0]      tx_byte
);

	localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	logic [7:0] mem_lo [NUM_REGS];
	logic [7:0] mem_hi [NUM_REGS];
	logic [NUM_REGS-1:0] vld_lo_q;
	logic [NUM_REGS-1:0] vld_hi_q;

	logic [2:0] pos_q;
	logic [7:0] cmd_q;
	logic [7:0] sel_q;

	logic       valid_s1;
	tx_sel_t    tx_sel_s1;
	logic [7:0] lo_s1;
	logic [7:0] hi_s1;
	logic       lo_ok_s1;
	logic       hi_ok_s1;

	logic       valid_s2;
	logic       tx_valid_s2;
	logic [7:0] tx_byte_s2;

	kind_t      kind;
	tx_sel_t    tx_sel;
	logic       accept;
	logic       adv2;
	logic       adv1;
	logic       in_range;
	logic [IDX_W-1:0] idx;
	logic       wr_lo;
	logic       wr_hi;
	logic [2:0] pos_inc;
	logic [7:0] byte_s1;

	always_comb begin
		if (start_seen && is_data && !buffer_full && clock_released) begin
			kind = KIND_NACK;
		end else if (start_seen && is_data && is_read && !buffer_full) begin
			kind = KIND_RD_DATA;
		end else if (start_seen && !is_data && is_read) begin
			kind = KIND_RD_ADDR;
		end else if (start_seen && is_data && !is_read && buffer_full) begin
			kind = KIND_WR_DATA;
		end else if (start_seen && !is_data && !is_read && buffer_full) begin
			kind = KIND_WR_ADDR;
		end else begin
			kind = KIND_NONE;
		end
	end

	always_comb begin
		case (kind)
			KIND_RD_DATA: tx_sel = (pos_q == POS_INDEX) ? TX_HIGH : TX_ZERO;
			KIND_RD_ADDR: tx_sel = TX_LOW;
			default:      tx_sel = TX_NONE;
		endcase
	end

	assign adv2     = !valid_s2 || !out_stall;
	assign adv1     = valid_s1 && adv2;
	assign in_stall = valid_s1 && !adv2;
	assign accept   = in_valid && !in_stall;

	assign in_range = {1'b0, sel_q} < 9'(NUM_REGS);
	assign idx      = sel_q[IDX_W-1:0];
	assign pos_inc  = (pos_q < POS_MAX) ? pos_q + 3'd1 : pos_q;

	assign wr_lo = accept && (kind == KIND_WR_DATA) && (pos_q == POS_LOW)
		&& (cmd_q == CMD_WRITE) && in_range;
	assign wr_hi = accept && (kind == KIND_WR_DATA) && (pos_q == POS_HIGH)
		&& (cmd_q == CMD_WRITE) && in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cmd_q <= CMD_READ;
			sel_q <= '0;
		end else if (accept) begin
			case (kind)
				KIND_NACK:    pos_q <= '0;
				KIND_RD_DATA: pos_q <= pos_inc;
				KIND_RD_ADDR: pos_q <= POS_INDEX;
				KIND_WR_DATA: begin
					if (pos_q == POS_CMD) begin
						cmd_q <= rx_byte;
					end else if (pos_q == POS_INDEX) begin
						sel_q <= rx_byte;
					end
					pos_q <= pos_inc;
				end
				KIND_WR_ADDR: pos_q <= '0;
				default:      pos_q <= pos_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_lo_q <= '0;
			vld_hi_q <= '0;
		end else begin
			if (wr_lo) begin
				vld_lo_q[idx] <= 1'b1;
			end
			if (wr_hi) begin
				vld_hi_q[idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_lo) begin
			mem_lo[idx] <= rx_byte;
		end
		if (wr_hi) begin
			mem_hi[idx] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_s1     <= mem_lo[idx];
			hi_s1     <= mem_hi[idx];
			lo_ok_s1  <= vld_lo_q[idx] && in_range;
			hi_ok_s1  <= vld_hi_q[idx] && in_range;
			tx_sel_s1 <= tx_sel;
		end
	end

	always_comb begin
		case (tx_sel_s1)
			TX_LOW:  byte_s1 = lo_ok_s1 ? lo_s1 : '0;
			TX_HIGH: byte_s1 = hi_ok_s1 ? hi_s1 : '0;
			default: byte_s1 = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			tx_valid_s2 <= (tx_sel_s1 != TX_NONE);
			tx_byte_s2  <= byte_s1;
		end
	end

	assign out_valid = valid_s2;
	assign tx_valid  = tx_valid_s2;
	assign tx_byte   = tx_byte_s2;

	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("byte position beyond saturation");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room in the pipeline");

	a_rd_addr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_RD_ADDR) |=> (pos_q == POS_INDEX))
		else $error("read address did not set position to one");

	a_no_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !tx_valid) |-> (tx_byte == 8'd0))
		else $error("byte sent without tx_valid");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> valid_s2)
		else $error("stalled result dropped");

endmodule
`default_nettype wire

@@ test/i2c_slave_register_access_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave register access - result checker
// Watches both item channels and predicts each transmit byte from its own
// copy of the byte position, command, register index and register file.
// Compares every accepted result with the oldest prediction and counts
// failures.
// ----------------------------------------------------------------------------
module i2c_slave_register_access_checker
	import i2csra_pkg::*;
#(
	parameter int NUM_REGS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic       start_seen,
	input  wire logic       is_data,
	input  wire logic       is_read,
	input  wire logic       buffer_full,
	input  wire logic       clock_released,
	input  wire logic [7:0] rx_byte,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic       tx_valid,
	input  wire logic [7:0] tx_byte,
	output int              fail_count,
	output int              queued
);

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} tx_item_t;

	tx_item_t    expected_tx[$];
	logic [2:0]  position;
	logic [7:0]  command;
	logic [7:0]  reg_index;
	logic [15:0] reg_image [NUM_REGS];

	function automatic kind_t decode_kind(input logic s, input logic d, input logic r,
			input logic b, input logic c);
		if (s && d && !b && c)
			return KIND_NACK;
		if (s && d && r && !b)
			return KIND_RD_DATA;
		if (s && !d && r)
			return KIND_RD_ADDR;
		if (s && d && !r && b)
			return KIND_WR_DATA;
		if (s && !d && !r && b)
			return KIND_WR_ADDR;
		return KIND_NONE;
	endfunction

	function automatic logic [7:0] read_half(input logic high);
		logic [15:0] word;
		if (reg_index >= NUM_REGS)
			return 8'd0;
		word = reg_image[reg_index];
		return high ? word[15:8] : word[7:0];
	endfunction

	function automatic void write_half(input logic high, input logic [7:0] value);
		if (reg_index < NUM_REGS) begin
			if (high)
				reg_image[reg_index][15:8] = value;
			else
				reg_image[reg_index][7:0] = value;
		end
	endfunction

	function automatic void advance_position();
		if (position < POS_MAX)
			position = position + 3'd1;
	endfunction

	function automatic tx_item_t serve_bus_event(input logic s, input logic d,
			input logic r, input logic b, input logic c, input logic [7:0] rx);
		tx_item_t result;
		result = '0;
		case (decode_kind(s, d, r, b, c))
			KIND_NACK: position = POS_CMD;
			KIND_RD_DATA: begin
				result.valid = 1'b1;
				result.data = (position == POS_INDEX) ? read_half(1'b1) : 8'd0;
				advance_position();
			end
			KIND_RD_ADDR: begin
				result.valid = 1'b1;
				result.data = read_half(1'b0);
				position = POS_INDEX;
			end
			KIND_WR_DATA: begin
				if (position == POS_CMD)
					command = rx;
				else if (position == POS_INDEX)
					reg_index = rx;
				else if (position == POS_LOW && command == CMD_WRITE)
					write_half(1'b0, rx);
				else if (position == POS_HIGH && command == CMD_WRITE)
					write_half(1'b1, rx);
				advance_position();
			end
			KIND_WR_ADDR: position = POS_CMD;
			default: ;
		endcase
		return result;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track_results
		tx_item_t oldest;
		if (!arst_n) begin
			position = POS_CMD;
			command = CMD_READ;
			reg_index = 8'd0;
			foreach (reg_image[i])
				reg_image[i] = 16'd0;
			expected_tx.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_tx.size() == 0) begin
					$error("unexpected result: tx_valid %0b tx_byte 0x%02h",
						tx_valid, tx_byte);
					fail_count++;
				end else begin
					oldest = expected_tx.pop_front();
					if (tx_valid !== oldest.valid) begin
						$error("tx_valid: expected %0b, actual %0b", oldest.valid, tx_valid);
						fail_count++;
					end
					if (tx_byte !== oldest.data) begin
						$error("tx_byte: expected 0x%02h, actual 0x%02h", oldest.data, tx_byte);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_tx.push_back(serve_bus_event(start_seen, is_data, is_read,
					buffer_full, clock_released, rx_byte));
		end
		queued = expected_tx.size();
	end

endmodule

@@ test/i2c_slave_register_access_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave register access - testbench top
// Drives directed and random bus event items with random gaps and output
// stalls, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module i2c_slave_register_access_tb
	import i2csra_pkg::*;
;

	localparam int NUM_REGS    = 16;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT = 400000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       start_seen;
	logic       is_data;
	logic       is_read;
	logic       buffer_full;
	logic       clock_released;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic       tx_valid;
	logic [7:0] tx_byte;
	int         fail_count;
	int         queued;
	int         sent_items = 0;
	int         cycle_count = 0;
	bit         steady = 1'b0;

	always #6 clk = ~clk;

	i2c_slave_register_access #(
		.NUM_REGS(NUM_REGS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_seen(start_seen),
		.is_data(is_data),
		.is_read(is_read),
		.buffer_full(buffer_full),
		.clock_released(clock_released),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte)
	);

	i2c_slave_register_access_checker #(
		.NUM_REGS(NUM_REGS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_seen(start_seen),
		.is_data(is_data),
		.is_read(is_read),
		.buffer_full(buffer_full),
		.clock_released(clock_released),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.fail_count(fail_count),
		.queued(queued)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int draw_wait();
		return steady ? 0 : int'($urandom_range(0, 12));
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_index();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, NUM_REGS + 1));
	endfunction

	task automatic send_event(input logic s, input logic d, input logic r, input logic b,
			input logic c, input logic [7:0] rx);
		int   gap;
		logic stalled;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_seen <= s;
		is_data <= d;
		is_read <= r;
		buffer_full <= b;
		clock_released <= c;
		rx_byte <= rx;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		sent_items++;
	endtask

	task automatic bus_write_addr();
		send_event(1'b1, 1'b0, 1'b0, 1'b1, rand_bit(), rand_byte());
	endtask

	task automatic bus_write_data(input logic [7:0] rx);
		send_event(1'b1, 1'b1, 1'b0, 1'b1, rand_bit(), rx);
	endtask

	task automatic bus_read_addr();
		send_event(1'b1, 1'b0, 1'b1, rand_bit(), rand_bit(), rand_byte());
	endtask

	task automatic bus_read_data();
		send_event(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, rand_byte());
	endtask

	task automatic bus_nack();
		send_event(1'b1, 1'b1, rand_bit(), 1'b0, 1'b1, rand_byte());
	endtask

	initial begin : drain_results
		int   hold;
		logic taken;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_wait();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				taken = out_valid;
				@(posedge clk);
			end while (!taken);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_seen = 1'b0;
		is_data = 1'b0;
		is_read = 1'b0;
		buffer_full = 1'b0;
		clock_released = 1'b0;
		rx_byte = 8'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no event kind, then read of the cleared file
		send_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
		send_event(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0);
		// write top register, both bytes, then saturate the position
		bus_write_addr();
		bus_write_data(CMD_WRITE);
		bus_write_data(8'(NUM_REGS - 1));
		bus_write_data(8'hFF);
		bus_write_data(8'hA5);
		bus_write_data(8'h00);
		bus_write_data(8'h5A);
		// read it back: low, high, zeros past the end
		bus_write_addr();
		bus_write_data(CMD_READ);
		bus_write_data(8'(NUM_REGS - 1));
		bus_read_addr();
		bus_read_data();
		bus_read_data();
		bus_read_data();
		bus_nack();
		bus_read_data();
		// index past the register file
		bus_write_addr();
		bus_write_data(CMD_WRITE);
		bus_write_data(8'hFF);
		bus_write_data(8'h12);
		bus_read_addr();
		// all ones and start missing
		send_event(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
		send_event(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);

		while (sent_items < RANDOM_ITEMS + 25) begin
			if ($urandom_range(0, 40) == 0)
				steady = !steady;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					bus_write_addr();
					bus_write_data(($urandom_range(0, 7) == 0) ? rand_byte() : CMD_WRITE);
					bus_write_data(pick_index());
					bus_write_data(rand_byte());
					if ($urandom_range(0, 3) != 0)
						bus_write_data(rand_byte());
					if ($urandom_range(0, 5) == 0)
						bus_write_data(rand_byte());
				end
				4, 5, 6: begin
					if ($urandom_range(0, 7) != 0)
						bus_write_addr();
					bus_write_data(($urandom_range(0, 7) == 0) ? rand_byte() : CMD_READ);
					bus_write_data(pick_index());
					bus_read_addr();
					repeat ($urandom_range(0, 4)) bus_read_data();
					if ($urandom_range(0, 1) != 0)
						bus_nack();
				end
				7: begin
					bus_read_addr();
					repeat ($urandom_range(0, 3)) bus_read_data();
					bus_nack();
				end
				default: begin
					repeat ($urandom_range(1, 4))
						send_event(rand_bit(), rand_bit(), rand_bit(), rand_bit(),
							rand_bit(), rand_byte());
				end
			endcase
		end
		in_valid <= 1'b0;

		do @(negedge clk); while (queued != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
